/* hdl/pfg_pkg.sv */
// ============================================================================
// pfg_pkg: shared types and constants for the pixel-to-gray converter
// Format codes, register indexes, the classified command that the front
// queues for the back, and the fixed-point coefficient sets.
// ============================================================================
`default_nettype none

package pfg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT = 3'd0,
        CFG_RED    = 3'd1,
        CFG_GREEN  = 3'd2,
        CFG_BLUE   = 3'd3,
        CFG_ALPHA  = 3'd4,
        CFG_PREMUL = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_RGB    = 2'd0,
        FMT_PLANAR = 2'd1,
        FMT_YUYV   = 2'd2,
        FMT_PASS   = 2'd3
    } t_fmt;

    // what the back has to do with one queued pixel
    typedef enum logic [2:0] {
        KIND_RGB     = 3'd0,   // packed rgb, channels used as they are
        KIND_RGB_DIV = 3'd1,   // packed rgb, undo premultiplied alpha
        KIND_PLANAR  = 3'd2,
        KIND_YUYV    = 3'd3,
        KIND_PASS    = 3'd4
    } t_kind;

    // c0..c3 by kind: rgb r,g,b,a; planar y,u,v,-; yuyv y0,u,v,y1; pass y,-,-,-
    typedef struct packed {
        t_kind      kind;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       az;
    } t_cmd;

    // signed accumulator width for the yuv conversions
    localparam int ACC_W = 27;
    localparam int K_W   = 18;

    // planar: integer BT.601, Q8
    localparam logic signed [K_W-1:0] PL_KY  = 18'sd298;
    localparam logic signed [K_W-1:0] PL_KRV = 18'sd409;
    localparam logic signed [K_W-1:0] PL_KGU = 18'sd100;
    localparam logic signed [K_W-1:0] PL_KGV = 18'sd208;
    localparam logic signed [K_W-1:0] PL_KBU = 18'sd516;
    localparam int                    PL_RND = 128;

    // yuyv: Q16 (1.0, 1.4075, 0.3455, 0.7169, 1.7790)
    localparam logic signed [K_W-1:0] YV_KY  = 18'sd65536;
    localparam logic signed [K_W-1:0] YV_KRV = 18'sd92242;
    localparam logic signed [K_W-1:0] YV_KGU = 18'sd22643;
    localparam logic signed [K_W-1:0] YV_KGV = 18'sd46983;
    localparam logic signed [K_W-1:0] YV_KBU = 18'sd116589;

    // luma weights, Q10
    localparam logic [9:0]  LUMA_R   = 10'd306;
    localparam logic [9:0]  LUMA_G   = 10'd601;
    localparam logic [9:0]  LUMA_B   = 10'd117;
    localparam logic [10:0] LUMA_RND = 11'h200;

    // divider: 8 quotient bits, DIV_STEPS per pipeline stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = 8 / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 1;

endpackage

`default_nettype wire

/* hdl/pfg_in_if.sv */
// ============================================================================
// pfg_in_if: pixel input channel
// valid/ready handshake carrying one pixel word and planar chroma per beat.
// ============================================================================
`default_nettype none

interface pfg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;
    logic [7:0]  chroma_u;
    logic [7:0]  chroma_v;

    modport source (output valid, pixel_word, chroma_u, chroma_v, input ready);
    modport sink   (input valid, pixel_word, chroma_u, chroma_v, output ready);
endinterface

`default_nettype wire

/* hdl/pfg_out_if.sv */
// ============================================================================
// pfg_out_if: gray output channel
// valid/ready handshake carrying one gray level and its flags per beat.
// ============================================================================
`default_nettype none

interface pfg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_value;
    logic       last;
    logic       alpha_zero;

    modport source (output valid, gray_value, last, alpha_zero, input ready);
    modport sink   (input valid, gray_value, last, alpha_zero, output ready);
endinterface

`default_nettype wire

/* hdl/pfg_udiv.sv */
// ============================================================================
// pfg_udiv: pipelined saturating divider for alpha un-premultiply
// Computes min(255, floor(num*255 / den)), DIV_STEPS quotient bits a stage.
// ============================================================================
`default_nettype none

module pfg_udiv (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [7:0] i_num,
    input  wire logic [7:0] i_den,
    output logic      [7:0] o_quo
);

    localparam int NS  = pfg_pkg::DIV_STAGES;
    localparam int SPS = pfg_pkg::DIV_STEPS;

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
        logic [7:0] den;
        logic       sat;
    } t_dstate;

    t_dstate r_st [NS+1];
    t_dstate n_st [NS+1];

    // one restoring step; rem < den holds on entry
    function automatic t_dstate div_step(input t_dstate s);
        t_dstate    o;
        logic [8:0] t;
        o     = s;
        t     = {s.rem, s.low[7]};
        o.low = {s.low[6:0], 1'b0};
        if (t >= {1'b0, s.den}) begin
            o.rem = 8'(t - {1'b0, s.den});
            o.quo = {s.quo[6:0], 1'b1};
        end else begin
            o.rem = t[7:0];
            o.quo = {s.quo[6:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        logic [15:0] prod;
        t_dstate     s;
        prod         = {i_num, 8'h00} - {8'h00, i_num};
        n_st[0].rem  = prod[15:8];
        n_st[0].low  = prod[7:0];
        n_st[0].quo  = '0;
        n_st[0].den  = i_den;
        // quotient above 255 iff num*255 >= 256*den
        n_st[0].sat  = (prod[15:8] >= i_den);
        for (int k = 0; k < NS; k++) begin
            s = r_st[k];
            for (int j = 0; j < SPS; j++) begin
                s = div_step(s);
            end
            n_st[k+1] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= NS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_quo = r_st[NS].sat ? 8'hFF : r_st[NS].quo;

endmodule

`default_nettype wire

/* hdl/pfg_queue.sv */
// ============================================================================
// pfg_queue: command queue between front and back
// Small register FIFO of classified pixels; head is read from a register.
// ============================================================================
`default_nettype none

module pfg_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pfg_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output pfg_pkg::t_cmd      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfg_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

/* hdl/pfg_front.sv */
// ============================================================================
// pfg_front: configuration registers and pixel classification
// Picks byte lanes per format and pushes one command per accepted beat.
// ============================================================================
`default_nettype none

module pfg_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pfg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pfg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pfg_in_if.sink                                i_pix,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output pfg_pkg::t_cmd                         o_cmd
);

    pfg_pkg::t_fmt r_mode;
    logic [1:0]    r_red;
    logic [1:0]    r_green;
    logic [1:0]    r_blue;
    logic [1:0]    r_alpha;
    logic          r_premul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pfg_pkg::FMT_RGB;
            r_red    <= 2'd1;
            r_green  <= 2'd2;
            r_blue   <= 2'd3;
            r_alpha  <= 2'd0;
            r_premul <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (pfg_pkg::t_cfg_idx'(i_cfg_idx))
                pfg_pkg::CFG_FORMAT: r_mode   <= pfg_pkg::t_fmt'(i_cfg_data);
                pfg_pkg::CFG_RED:    r_red    <= i_cfg_data;
                pfg_pkg::CFG_GREEN:  r_green  <= i_cfg_data;
                pfg_pkg::CFG_BLUE:   r_blue   <= i_cfg_data;
                pfg_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_data;
                pfg_pkg::CFG_PREMUL: r_premul <= i_cfg_data[0];
                default:             ;  // unmapped index, ignored
            endcase
        end
    end

    logic [31:0] w_word;
    logic [7:0]  w_r, w_g, w_b, w_a;

    assign w_word = i_pix.pixel_word;
    assign w_r    = w_word[{r_red,   3'b000} +: 8];
    assign w_g    = w_word[{r_green, 3'b000} +: 8];
    assign w_b    = w_word[{r_blue,  3'b000} +: 8];
    assign w_a    = w_word[{r_alpha, 3'b000} +: 8];

    always_comb begin
        o_cmd    = '0;
        o_cmd.c0 = w_word[7:0];
        unique case (r_mode)
            pfg_pkg::FMT_RGB: begin
                o_cmd.c0 = w_r;
                o_cmd.c1 = w_g;
                o_cmd.c2 = w_b;
                o_cmd.c3 = w_a;
                o_cmd.az = r_premul && (w_a == 8'd0);
                o_cmd.kind = (r_premul && (w_a != 8'd0)) ? pfg_pkg::KIND_RGB_DIV
                                                         : pfg_pkg::KIND_RGB;
            end
            pfg_pkg::FMT_PLANAR: begin
                o_cmd.kind = pfg_pkg::KIND_PLANAR;
                o_cmd.c1   = i_pix.chroma_u;
                o_cmd.c2   = i_pix.chroma_v;
            end
            pfg_pkg::FMT_YUYV: begin
                o_cmd.kind = pfg_pkg::KIND_YUYV;
                o_cmd.c1   = w_word[15:8];
                o_cmd.c2   = w_word[31:24];
                o_cmd.c3   = w_word[23:16];
            end
            default: begin
                o_cmd.kind = pfg_pkg::KIND_PASS;
            end
        endcase
    end

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

endmodule

`default_nettype wire

/* hdl/pfg_back.sv */
// ============================================================================
// pfg_back: conversion and luma pipeline
// Issues one result per cycle, unless stalled, from the queue head (two for
// yuyv), runs yuv products, clamp, un-premultiply divider, luma, output reg.
// ============================================================================
`default_nettype none

module pfg_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pfg_pkg::t_cmd i_cmd,
    output logic               o_pop,
    pfg_out_if.source          o_gray
);

    localparam int AW = pfg_pkg::ACC_W;
    localparam int KW = pfg_pkg::K_W;
    localparam int DL = pfg_pkg::DIV_LAT;

    typedef struct packed {
        logic            valid;
        pfg_pkg::t_kind  kind;
        logic [7:0]      y;
        logic [7:0]      u;
        logic [7:0]      v;
        logic [7:0]      a;
        logic            az;
        logic            last;
        logic signed [AW-1:0] ay;
        logic signed [AW-1:0] re;
        logic signed [AW-1:0] gu;
        logic signed [AW-1:0] gv;
        logic signed [AW-1:0] bu;
    } t_s1;

    typedef struct packed {
        logic       valid;
        logic       div;
        logic       az;
        logic       last;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_ch;

    typedef struct packed {
        logic        valid;
        logic        az;
        logic        last;
        logic [17:0] pr;
        logic [17:0] pg;
        logic [17:0] pb;
    } t_l1;

    // floor(s / 2^8 or 2^16) clamped to 0..255
    function automatic logic [7:0] clamp_shift(input logic signed [AW-1:0] s,
                                               input logic q16);
        logic [AW-1:0] q;
        q = q16 ? ($unsigned(s) >> 16) : ($unsigned(s) >> 8);
        if (s[AW-1]) begin
            return 8'd0;
        end
        return (|q[AW-1:8]) ? 8'hFF : q[7:0];
    endfunction

    logic r_half;        // second yuyv result is next
    logic r_out_valid;
    logic w_adv;         // whole pipeline moves

    assign w_adv = !r_out_valid || o_gray.ready;

    // ---- issue -----------------------------------------------------------
    logic w_yuyv;
    assign w_yuyv = (i_cmd.kind == pfg_pkg::KIND_YUYV);
    assign o_pop  = w_adv && i_valid && (!w_yuyv || r_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (w_adv && i_valid && w_yuyv) begin
            r_half <= !r_half;
        end
    end

    // ---- stage 1: conversion products -----------------------------------
    t_s1 r_s1, n_s1;

    always_comb begin
        logic [7:0]              y;
        logic signed [9:0]       yop;
        logic signed [8:0]       d, e;
        logic signed [KW-1:0]    ky, krv, kgu, kgv, kbu;
        logic                    planar;
        y      = (w_yuyv && r_half) ? i_cmd.c3 : i_cmd.c0;
        d      = $signed({1'b0, i_cmd.c1}) - 9'sd128;
        e      = $signed({1'b0, i_cmd.c2}) - 9'sd128;
        planar = (i_cmd.kind == pfg_pkg::KIND_PLANAR);
        yop    = planar ? ($signed({2'b00, y}) - 10'sd16) : $signed({2'b00, y});
        ky     = planar ? pfg_pkg::PL_KY  : pfg_pkg::YV_KY;
        krv    = planar ? pfg_pkg::PL_KRV : pfg_pkg::YV_KRV;
        kgu    = planar ? pfg_pkg::PL_KGU : pfg_pkg::YV_KGU;
        kgv    = planar ? pfg_pkg::PL_KGV : pfg_pkg::YV_KGV;
        kbu    = planar ? pfg_pkg::PL_KBU : pfg_pkg::YV_KBU;

        n_s1.valid = i_valid;
        n_s1.kind  = i_cmd.kind;
        n_s1.y     = y;
        n_s1.u     = i_cmd.c1;
        n_s1.v     = i_cmd.c2;
        n_s1.a     = i_cmd.c3;
        n_s1.az    = i_cmd.az;
        n_s1.last  = !(w_yuyv && !r_half);
        n_s1.ay    = AW'(yop) * AW'(ky);
        n_s1.re    = AW'(e) * AW'(krv);
        n_s1.gu    = AW'(d) * AW'(kgu);
        n_s1.gv    = AW'(e) * AW'(kgv);
        n_s1.bu    = AW'(d) * AW'(kbu);
    end

    // ---- stage 2: sums, clamp, channel select ---------------------------
    t_ch        r_s2, n_s2;
    logic [7:0] r_s2_a;

    always_comb begin
        logic signed [AW-1:0] rnd, sr, sg, sb;
        logic                 q16;
        rnd = (r_s1.kind == pfg_pkg::KIND_PLANAR) ? AW'(pfg_pkg::PL_RND) : '0;
        q16 = (r_s1.kind == pfg_pkg::KIND_YUYV);
        sr  = r_s1.ay + r_s1.re + rnd;
        sg  = r_s1.ay - r_s1.gu - r_s1.gv + rnd;
        sb  = r_s1.ay + r_s1.bu + rnd;

        n_s2.valid = r_s1.valid;
        n_s2.div   = (r_s1.kind == pfg_pkg::KIND_RGB_DIV);
        n_s2.az    = r_s1.az;
        n_s2.last  = r_s1.last;
        unique case (r_s1.kind)
            pfg_pkg::KIND_RGB, pfg_pkg::KIND_RGB_DIV: begin
                n_s2.r = r_s1.y;
                n_s2.g = r_s1.u;
                n_s2.b = r_s1.v;
            end
            pfg_pkg::KIND_PLANAR, pfg_pkg::KIND_YUYV: begin
                n_s2.r = clamp_shift(sr, q16);
                n_s2.g = clamp_shift(sg, q16);
                n_s2.b = clamp_shift(sb, q16);
            end
            default: begin
                // luma weights sum to 1024, so equal channels give y back
                n_s2.r = r_s1.y;
                n_s2.g = r_s1.y;
                n_s2.b = r_s1.y;
            end
        endcase
    end

    // ---- divider stages with matching sideband ---------------------------
    logic [7:0] w_qr, w_qg, w_qb;
    t_ch        r_sb [DL];

    pfg_udiv u_div_r (.i_clk(i_clk), .i_en(w_adv), .i_num(r_s2.r), .i_den(r_s2_a),
                      .o_quo(w_qr));
    pfg_udiv u_div_g (.i_clk(i_clk), .i_en(w_adv), .i_num(r_s2.g), .i_den(r_s2_a),
                      .o_quo(w_qg));
    pfg_udiv u_div_b (.i_clk(i_clk), .i_en(w_adv), .i_num(r_s2.b), .i_den(r_s2_a),
                      .o_quo(w_qb));

    // ---- luma products ---------------------------------------------------
    t_l1        r_l1, n_l1;

    always_comb begin
        logic [7:0] r, g, b;
        r = r_sb[DL-1].div ? w_qr : r_sb[DL-1].r;
        g = r_sb[DL-1].div ? w_qg : r_sb[DL-1].g;
        b = r_sb[DL-1].div ? w_qb : r_sb[DL-1].b;
        n_l1.valid = r_sb[DL-1].valid;
        n_l1.az    = r_sb[DL-1].az;
        n_l1.last  = r_sb[DL-1].last;
        n_l1.pr    = 18'(r) * 18'(pfg_pkg::LUMA_R);
        n_l1.pg    = 18'(g) * 18'(pfg_pkg::LUMA_G);
        n_l1.pb    = 18'(b) * 18'(pfg_pkg::LUMA_B);
    end

    logic [18:0] w_sum;
    assign w_sum = 19'(r_l1.pr) + 19'(r_l1.pg) + 19'(r_l1.pb) + 19'(pfg_pkg::LUMA_RND);

    // ---- pipeline registers ----------------------------------------------
    logic [7:0] r_gray;
    logic       r_last;
    logic       r_az;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            for (int k = 0; k < DL; k++) begin
                r_sb[k].valid <= 1'b0;
            end
            r_l1.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_sb[0] <= r_s2;
            for (int k = 1; k < DL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_l1        <= n_l1;
            r_out_valid <= r_l1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_a <= r_s1.a;
            r_gray <= w_sum[17:10];
            r_last <= r_l1.last;
            r_az   <= r_l1.az;
        end
    end

    assign o_gray.valid      = r_out_valid;
    assign o_gray.gray_value = r_gray;
    assign o_gray.last       = r_last;
    assign o_gray.alpha_zero = r_az;

endmodule

`default_nettype wire

/* hdl/pixel_format_to_gray_unit.sv */
// ============================================================================
// pixel_format_to_gray_unit: pixel word to 8-bit gray converter
// Front classifies pixels into a short queue; back pipeline computes gray.
// ============================================================================
// Usage
//   i_pix   : pixel beats (valid/ready). pixel_word holds four byte lanes;
//             chroma_u/chroma_v are only looked at in planar yuv mode.
//   o_gray  : gray beats (valid/ready). One beat per pixel, two for a yuyv
//             pair (last low on the y0 beat, high on the y1 beat).
//   i_cfg_* : register writes, one per cycle while i_cfg_we is high; only
//             change them with the block drained.
// Throughput: one pixel per cycle while the output is not stalled; a yuyv
//   pixel holds the issue stage until both its gray beats are issued. The
//   issue stage and the 9-stage back pipeline move together on a single
//   advance enable.
// Reset (synchronous, active low) empties the queue and the pipeline and
//   loads the register defaults: packed rgb, red lane 1, green 2, blue 3,
//   alpha 0, premultiply off.
// Stall: a full output register with ready low freezes the back; the queue
//   keeps taking pixels until it is full, then i_pix.ready drops.
// ============================================================================
`default_nettype none

module pixel_format_to_gray_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pfg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pfg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pfg_in_if.sink                              i_pix,
    pfg_out_if.source                           o_gray
);

    // front -> queue
    logic          w_push;
    logic          w_full;
    pfg_pkg::t_cmd w_cmd_in;

    // queue -> back
    logic          w_head_valid;
    logic          w_pop;
    pfg_pkg::t_cmd w_head;

    pfg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // decouples input acceptance from back-pressure on the output
    pfg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    // products, clamp, divider, luma, output register
    pfg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_cmd   (w_head),
        .o_pop   (w_pop),
        .o_gray  (o_gray)
    );

endmodule

`default_nettype wire

/* hdl/pfg_checker.sv */
// ============================================================================
// pfg_checker: port-level checks for the pixel-to-gray converter
// Output handshake rules, flag consistency and yuyv pair delivery.
// ============================================================================
`default_nettype none

module pfg_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_gray,
    input wire logic       i_out_last,
    input wire logic       i_out_az
);

    // a stalled beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("gray beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_gray) && $stable(i_out_last) && $stable(i_out_az))
        else $error("gray payload changed while stalled");

    // zero alpha only comes with a single-beat pixel
    a_az_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_az |-> i_out_last)
        else $error("alpha_zero on a non-final beat");

    // second yuyv beat follows the first directly
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last)
        else $error("yuyv pair split");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind pixel_format_to_gray_unit pfg_checker u_pfg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_gray.valid),
    .i_out_ready (o_gray.ready),
    .i_out_gray  (o_gray.gray_value),
    .i_out_last  (o_gray.last),
    .i_out_az    (o_gray.alpha_zero)
);

`default_nettype wire
